// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define ASSERT_NEXT(label, clk, rst, cond, outcome, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
    else $error(msg);

`endif

// File: hdl/gcf_pkg.sv
// Types, constants and tanh tables for the GRU cell forward unit.
`default_nettype none

package gcf_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int GATE_WIDTH    = 13;
  localparam int NEW_WIDTH     = 14;
  localparam int FRAC_BITS     = 12;
  localparam int QONE          = 4096;
  localparam int TANH_SEGMENTS = 64;
  localparam int SEG_BITS      = $clog2(TANH_SEGMENTS);
  localparam int TANH_IN_WIDTH = 18;
  localparam int TDIFF_W       = 15;

  localparam logic [63:0] EXP_ONE = 64'd1 << 30;

  typedef logic signed [DATA_WIDTH-1:0]    data_t;
  typedef logic [GATE_WIDTH-1:0]           gate_t;
  typedef logic signed [NEW_WIDTH-1:0]     new_t;
  typedef logic signed [TANH_IN_WIDTH-1:0] tanh_in_t;

  typedef logic [TANH_SEGMENTS-1:0][NEW_WIDTH-1:0] tanh_tab_t;
  typedef logic [TANH_SEGMENTS-1:0][TDIFF_W-1:0]   tanh_diff_tab_t;

  // Stage enables of one tanh unit.
  typedef struct packed {
    logic look;
    logic mul;
    logic sum;
  } tanh_en_t;

  // Restoring division, used only while the tables are built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh at breakpoint k, Q.12: exp(-2|t|) by a series on 2|t|/16, squared four times.
  function automatic longint tanh_point(int k);
    longint      num;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] res;
    longint      acc;
    num = longint'(32 * k) - longint'(16 * TANH_SEGMENTS);
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    w   = udiv64(mag << 30, 64'(16 * TANH_SEGMENTS));
    if (w > EXP_ONE) w = EXP_ONE;
    acc  = longint'(EXP_ONE);
    term = EXP_ONE;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * w) >> 30, 64'(n));
      if (n[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    e = 64'(acc);
    if (e > EXP_ONE) e = EXP_ONE;
    for (int n = 0; n < 4; n++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = EXP_ONE + e;
    res = udiv64((EXP_ONE - e) * 64'(QONE) + (den >> 1), den);
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic tanh_tab_t tanh_base_tab();
    tanh_tab_t tab;
    for (int k = 0; k < TANH_SEGMENTS; k++) begin
      tab[k] = NEW_WIDTH'(tanh_point(k));
    end
    return tab;
  endfunction

  function automatic tanh_diff_tab_t tanh_diff_tab();
    tanh_diff_tab_t tab;
    for (int k = 0; k < TANH_SEGMENTS; k++) begin
      tab[k] = TDIFF_W'(tanh_point(k + 1) - tanh_point(k));
    end
    return tab;
  endfunction

  localparam tanh_tab_t      TANH_BASE = tanh_base_tab();
  localparam tanh_diff_tab_t TANH_DIFF = tanh_diff_tab();

endpackage

`default_nettype wire

// File: hdl/gcf_item_if.sv
// Input channel: gate pre-activations, previous hidden value and biases.
`default_nettype none

interface gcf_item_if;
  import gcf_pkg::*;

  logic  valid;
  logic  ready;
  data_t in_reset_pre;
  data_t in_update_pre;
  data_t in_new_pre;
  data_t hid_reset_pre;
  data_t hid_update_pre;
  data_t hid_new_pre;
  data_t prev_hidden;
  data_t reset_bias_sum;
  data_t update_bias_sum;
  data_t in_new_bias;
  data_t hid_new_bias;

  modport source (
    output valid, in_reset_pre, in_update_pre, in_new_pre, hid_reset_pre,
           hid_update_pre, hid_new_pre, prev_hidden, reset_bias_sum,
           update_bias_sum, in_new_bias, hid_new_bias,
    input  ready
  );

  modport sink (
    input  valid, in_reset_pre, in_update_pre, in_new_pre, hid_reset_pre,
           hid_update_pre, hid_new_pre, prev_hidden, reset_bias_sum,
           update_bias_sum, in_new_bias, hid_new_bias,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/gcf_result_if.sv
// Output channel: new hidden value, gates and biased hidden candidate.
`default_nettype none

interface gcf_result_if;
  import gcf_pkg::*;

  logic  valid;
  logic  ready;
  data_t next_hidden;
  gate_t reset_gate;
  gate_t update_gate;
  new_t  new_gate;
  data_t hid_new_biased;

  modport source (
    output valid, next_hidden, reset_gate, update_gate, new_gate, hid_new_biased,
    input  ready
  );

  modport sink (
    input  valid, next_hidden, reset_gate, update_gate, new_gate, hid_new_biased,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/gcf_tanh.sv
// Three-stage tanh: segment lookup, slope multiply, rounded interpolation.
`default_nettype none

module gcf_tanh (
  input  logic               clk,
  input  gcf_pkg::tanh_en_t  en,
  input  gcf_pkg::tanh_in_t  x,
  output gcf_pkg::new_t      y
);
  import gcf_pkg::*;

  localparam new_t T_ONE = new_t'(QONE);

  logic                  sat_lo;
  logic                  sat_hi;
  logic [15:0]           u;
  logic [SEG_BITS-1:0]   seg;
  logic [15:0]           frac;

  // lookup stage
  logic                  lo1;
  logic                  hi1;
  new_t                  base1;
  logic signed [TDIFF_W-1:0] diff1;
  logic [15:0]           frac1;

  // multiply stage
  logic                  lo2;
  logic                  hi2;
  new_t                  base2;
  logic signed [TDIFF_W+16:0] prod2;

  logic signed [TDIFF_W+17:0] rnd_sum;
  logic signed [TDIFF_W+1:0]  step;

  assign sat_lo = (x < -tanh_in_t'(32768));
  assign sat_hi = (x >= tanh_in_t'(32768));
  // x + 32768 within range: flip the sign bit of the low 16 bits
  assign u      = x[15:0] ^ 16'h8000;
  assign seg    = u[15 -: SEG_BITS];
  assign frac   = {u[15-SEG_BITS:0], {SEG_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (en.look) begin
      lo1   <= sat_lo;
      hi1   <= sat_hi;
      base1 <= TANH_BASE[seg];
      diff1 <= TANH_DIFF[seg];
      frac1 <= frac;
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      lo2   <= lo1;
      hi2   <= hi1;
      base2 <= base1;
      prod2 <= diff1 * $signed({1'b0, frac1});
    end
  end

  assign rnd_sum = (TDIFF_W+18)'(prod2) + (TDIFF_W+18)'(32768);
  assign step    = rnd_sum[TDIFF_W+17:16];

  always_ff @(posedge clk) begin
    if (en.sum) begin
      if (lo2)      y <= -T_ONE;
      else if (hi2) y <= T_ONE;
      else          y <= NEW_WIDTH'((TDIFF_W+2)'(base2) + step);
    end
  end

endmodule

`default_nettype wire

// File: hdl/gru_cell_forward_unit.sv
// Top level of the GRU cell forward unit.
`default_nettype none
`include "assert_macros.svh"

// One hidden unit of a GRU cell per word, Q4.12 fixed point. The block takes one word
// per clock, unless held by a stalled result side, through a 12-stage pipeline of
// bias sums, two tanh units for the reset and update gates (sigmoid taken as a halved
// tanh), the r*hn' multiply, a third tanh unit for the candidate, the (hx-n)*z multiply
// and the final saturating add. Each tanh unit is three stages: lookup in a 64-segment
// table built at elaboration, slope multiply, rounded interpolation. Every stage moves
// when any later stage has room or the result is taken, so bubbles close up and the
// input stays ready while a finished result waits, as long as one stage is empty.
// Sustained rate is one word per cycle while results are taken.
module gru_cell_forward_unit (
  input  logic         clk,
  input  logic         rst,
  gcf_item_if.sink     item,
  gcf_result_if.source result
);
  import gcf_pkg::*;

  localparam int STAGES = 12;

  logic [STAGES-1:0] v;
  logic [STAGES:0]   adv;

  // stage 0
  logic signed [17:0] sum_r0;
  logic signed [17:0] sum_z0;
  logic signed [16:0] hn_sum;
  data_t              hnb_sat;

  data_t              hnb_q [0:STAGES-1];
  data_t              hx_q  [0:9];
  logic signed [16:0] inb_q [0:5];
  gate_t              r_q   [4:STAGES-1];
  gate_t              z_q   [4:STAGES-1];

  tanh_en_t           en_r;
  tanh_en_t           en_n;
  tanh_in_t           x_r;
  tanh_in_t           x_z;
  new_t               t_r;
  new_t               t_z;
  logic signed [14:0] sg_r;
  logic signed [14:0] sg_z;

  logic signed [29:0] rh_prod5;
  logic signed [29:0] rh_sum;
  logic signed [17:0] rh;
  tanh_in_t           xn6;
  new_t               n_y;

  logic signed [16:0] hx_diff;
  logic signed [30:0] prod10;
  new_t               n10;
  logic signed [30:0] sc_sum;
  logic signed [19:0] hy_w;
  data_t              hy11;
  new_t               n11;

  logic               gates_ok;
  logic               new_ok;

  // a stage can move when any later stage is empty or the result is taken
  always_comb begin
    logic room;
    room        = result.ready;
    adv[STAGES] = room;
    for (int s = STAGES - 1; s >= 0; s--) begin
      room   = room | ~v[s];
      adv[s] = room;
    end
  end

  assign item.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= item.valid;
      for (int s = 1; s < STAGES; s++) begin
        if (adv[s]) v[s] <= v[s-1];
      end
    end
  end

  // stage 0: bias sums
  assign hn_sum = 17'(item.hid_new_pre) + 17'(item.hid_new_bias);
  always_comb begin
    if (hn_sum[16] != hn_sum[15]) hnb_sat = hn_sum[16] ? 16'sh8000 : 16'sh7fff;
    else                          hnb_sat = hn_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sum_r0   <= 18'(item.in_reset_pre) + 18'(item.hid_reset_pre)
                + 18'(item.reset_bias_sum);
      sum_z0   <= 18'(item.in_update_pre) + 18'(item.hid_update_pre)
                + 18'(item.update_bias_sum);
    end
  end

  // side data shift lines
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      hnb_q[0] <= hnb_sat;
      inb_q[0] <= 17'(item.in_new_pre) + 17'(item.in_new_bias);
      hx_q[0]  <= item.prev_hidden;
    end
    // stage 4: sigmoid = (1 + tanh) / 2, rounded
    if (adv[4]) begin
      r_q[4] <= sg_r[13:1];
      z_q[4] <= sg_z[13:1];
    end
    for (int s = 1; s < STAGES; s++) begin
      if (adv[s]) hnb_q[s] <= hnb_q[s-1];
    end
    for (int s = 1; s <= 9; s++) begin
      if (adv[s]) hx_q[s] <= hx_q[s-1];
    end
    for (int s = 1; s <= 5; s++) begin
      if (adv[s]) inb_q[s] <= inb_q[s-1];
    end
    for (int s = 5; s < STAGES; s++) begin
      if (adv[s]) begin
        r_q[s] <= r_q[s-1];
        z_q[s] <= z_q[s-1];
      end
    end
  end

  // stages 1..3: gate tanh on floor(x/2)
  assign en_r = '{look: adv[1], mul: adv[2], sum: adv[3]};
  assign x_r  = {sum_r0[17], sum_r0[17:1]};
  assign x_z  = {sum_z0[17], sum_z0[17:1]};

  gcf_tanh u_tanh_r (
    .clk (clk),
    .en  (en_r),
    .x   (x_r),
    .y   (t_r)
  );

  gcf_tanh u_tanh_z (
    .clk (clk),
    .en  (en_r),
    .x   (x_z),
    .y   (t_z)
  );

  assign sg_r = 15'(t_r) + 15'sd4097;
  assign sg_z = 15'(t_z) + 15'sd4097;

  // stage 5: r * hn'
  always_ff @(posedge clk) begin
    if (adv[5]) rh_prod5 <= $signed({1'b0, r_q[4]}) * hnb_q[4];
  end

  // stage 6: candidate argument
  assign rh_sum = rh_prod5 + 30'sd2048;
  assign rh     = rh_sum[29:12];

  always_ff @(posedge clk) begin
    if (adv[6]) xn6 <= 18'(inb_q[5]) + rh;
  end

  // stages 7..9: candidate tanh
  assign en_n = '{look: adv[7], mul: adv[8], sum: adv[9]};

  gcf_tanh u_tanh_n (
    .clk (clk),
    .en  (en_n),
    .x   (xn6),
    .y   (n_y)
  );

  // stage 10: (hx - n) * z
  assign hx_diff = 17'(hx_q[9]) - 17'(n_y);

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      prod10 <= hx_diff * $signed({1'b0, z_q[9]});
      n10    <= n_y;
    end
  end

  // stage 11: round, add n, saturate
  assign sc_sum = prod10 + 31'sd2048;
  assign hy_w   = 20'($signed(sc_sum[30:12])) + 20'(n10);

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      if (hy_w > 20'sd32767)       hy11 <= 16'sh7fff;
      else if (hy_w < -20'sd32768) hy11 <= 16'sh8000;
      else                         hy11 <= hy_w[15:0];
      n11 <= n10;
    end
  end

  assign result.valid          = v[STAGES-1];
  assign result.next_hidden    = hy11;
  assign result.reset_gate     = r_q[STAGES-1];
  assign result.update_gate    = z_q[STAGES-1];
  assign result.new_gate       = n11;
  assign result.hid_new_biased = hnb_q[STAGES-1];

  assign gates_ok = (result.reset_gate <= gate_t'(QONE))
                 && (result.update_gate <= gate_t'(QONE));
  assign new_ok   = (result.new_gate <= new_t'(QONE)) && (result.new_gate >= -new_t'(QONE));

  `ASSERT_CLK(a_gate_range, clk, rst, result.valid |-> gates_ok, "gate above one")
  `ASSERT_CLK(a_new_range, clk, rst, result.valid |-> new_ok, "candidate outside unit range")
  `ASSERT_NEXT(a_last_move, clk, rst, v[10] && adv[10], v[11], "word lost entering output stage")
  `ASSERT_CLK(a_ready_free, clk, rst, !v[STAGES-1] |-> item.ready, "input stalled with output stage empty")

endmodule

`default_nettype wire

// File: dv/gru_cell_forward_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GRU cell forward unit: directed corners, then random words.
module gru_cell_forward_unit_tb;
  import gcf_pkg::*;

  localparam int        HALF_PERIOD  = 6;
  localparam int        RESET_CYCLES = 9;
  localparam int        QUIET_LIMIT  = 2000;
  localparam int        HOLD_CYCLES  = 250;
  localparam int        DRAIN_CYCLES = 24;
  localparam bit [63:0] Q30_ONE      = 64'd1 << 30;
  localparam longint    SAT_HI       = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint    SAT_LO       = -SAT_HI - 1;

  typedef enum int {MIX_FULL, MIX_GATED, MIX_NO_BIAS, MIX_EDGES} word_mix_t;

  typedef struct {
    data_t in_reset_pre;
    data_t in_update_pre;
    data_t in_new_pre;
    data_t hid_reset_pre;
    data_t hid_update_pre;
    data_t hid_new_pre;
    data_t prev_hidden;
    data_t reset_bias_sum;
    data_t update_bias_sum;
    data_t in_new_bias;
    data_t hid_new_bias;
  } gru_word_t;

  typedef struct {
    data_t next_hidden;
    gate_t reset_gate;
    gate_t update_gate;
    new_t  new_gate;
    data_t hid_new_biased;
  } gru_out_t;

  logic clk;
  logic rst;

  gcf_item_if   item_ch ();
  gcf_result_if result_ch ();

  gru_cell_forward_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  longint   tanh_knee [0:TANH_SEGMENTS];
  gru_out_t gru_outputs_due [$];
  int       errors = 0;
  bit       send_no_idle = 1'b0;
  bit       sink_no_idle = 1'b0;
  bit       hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // tanh at breakpoint k in Q.12; exp(-2|t|) from a 20-term series on 2|t|/16, squared 4x
  function automatic longint knee_value(int k);
    longint    num;
    longint    acc;
    bit        neg;
    bit [63:0] mag;
    bit [63:0] w;
    bit [63:0] term;
    bit [63:0] e;
    bit [63:0] den;
    bit [63:0] mval;
    int        n;
    num = longint'(32 * k) - longint'(16 * TANH_SEGMENTS);
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    w = (mag << 30) / 64'(16 * TANH_SEGMENTS);
    if (w > Q30_ONE) w = Q30_ONE;
    acc  = longint'(Q30_ONE);
    term = Q30_ONE;
    for (n = 1; n <= 20; n++) begin
      term = ((term * w) >> 30) / 64'(n);
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    e = 64'(acc);
    if (e > Q30_ONE) e = Q30_ONE;
    repeat (4) e = (e * e + (64'd1 << 29)) >> 30;
    den  = Q30_ONE + e;
    mval = ((Q30_ONE - e) * 64'(QONE) + (den >> 1)) / den;
    return neg ? -longint'(mval) : longint'(mval);
  endfunction

  function automatic longint tanh_fx(longint x);
    longint p;
    longint k;
    longint f;
    longint t0;
    longint t1;
    if (x < -32768) return -QONE;
    if (x >= 32768) return QONE;
    p  = (x + 32768) * TANH_SEGMENTS;
    k  = p >>> 16;
    f  = p & 64'hFFFF;
    t0 = tanh_knee[k];
    t1 = tanh_knee[k + 1];
    return t0 + (((t1 - t0) * f + 32768) >>> 16);
  endfunction

  function automatic longint sigmoid_fx(longint x);
    return (QONE + tanh_fx(x >>> 1) + 1) >>> 1;
  endfunction

  function automatic longint sat_data(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic gru_out_t gru_unit_model(gru_word_t w);
    longint   r;
    longint   z;
    longint   hnb;
    longint   rh;
    longint   n;
    longint   sc;
    gru_out_t o;
    r   = sigmoid_fx(longint'(w.in_reset_pre) + longint'(w.hid_reset_pre)
                     + longint'(w.reset_bias_sum));
    z   = sigmoid_fx(longint'(w.in_update_pre) + longint'(w.hid_update_pre)
                     + longint'(w.update_bias_sum));
    hnb = sat_data(longint'(w.hid_new_pre) + longint'(w.hid_new_bias));
    rh  = (r * hnb + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    n   = tanh_fx(longint'(w.in_new_pre) + longint'(w.in_new_bias) + rh);
    sc  = ((longint'(w.prev_hidden) - n) * z + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    o.next_hidden    = data_t'(sat_data(sc + n));
    o.reset_gate     = gate_t'(r);
    o.update_gate    = gate_t'(z);
    o.new_gate       = new_t'(n);
    o.hid_new_biased = data_t'(hnb);
    return o;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic data_t rand_value(word_mix_t mix);
    case (mix)
      MIX_GATED, MIX_NO_BIAS: begin
        return data_t'(int'($urandom_range(22000)) - 11000);
      end
      MIX_EDGES: begin
        case ($urandom_range(5))
          0: return data_t'(32767);
          1: return data_t'(-32768);
          2: return data_t'(0);
          3: return data_t'(-1);
          4: return data_t'(1);
          default: return data_t'($urandom());
        endcase
      end
      default: return data_t'($urandom());
    endcase
  endfunction

  function automatic gru_word_t rand_word(word_mix_t mix);
    gru_word_t w;
    w.in_reset_pre    = rand_value(mix);
    w.in_update_pre   = rand_value(mix);
    w.in_new_pre      = rand_value(mix);
    w.hid_reset_pre   = rand_value(mix);
    w.hid_update_pre  = rand_value(mix);
    w.hid_new_pre     = rand_value(mix);
    w.prev_hidden     = rand_value(mix);
    w.reset_bias_sum  = rand_value(mix);
    w.update_bias_sum = rand_value(mix);
    w.in_new_bias     = rand_value(mix);
    w.hid_new_bias    = rand_value(mix);
    if (mix == MIX_NO_BIAS) begin
      w.reset_bias_sum  = '0;
      w.update_bias_sum = '0;
      w.in_new_bias     = '0;
      w.hid_new_bias    = '0;
    end
    return w;
  endfunction

  function automatic gru_word_t uniform_word(data_t v);
    gru_word_t w;
    w.in_reset_pre    = v;
    w.in_update_pre   = v;
    w.in_new_pre      = v;
    w.hid_reset_pre   = v;
    w.hid_update_pre  = v;
    w.hid_new_pre     = v;
    w.prev_hidden     = v;
    w.reset_bias_sum  = v;
    w.update_bias_sum = v;
    w.in_new_bias     = v;
    w.hid_new_bias    = v;
    return w;
  endfunction

  // valid stays high across back-to-back words; it only drops for a gap
  task automatic send_word(gru_word_t w);
    int gap;
    gap = send_no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.in_reset_pre    <= w.in_reset_pre;
    item_ch.in_update_pre   <= w.in_update_pre;
    item_ch.in_new_pre      <= w.in_new_pre;
    item_ch.hid_reset_pre   <= w.hid_reset_pre;
    item_ch.hid_update_pre  <= w.hid_update_pre;
    item_ch.hid_new_pre     <= w.hid_new_pre;
    item_ch.prev_hidden     <= w.prev_hidden;
    item_ch.reset_bias_sum  <= w.reset_bias_sum;
    item_ch.update_bias_sum <= w.update_bias_sum;
    item_ch.in_new_bias     <= w.in_new_bias;
    item_ch.hid_new_bias    <= w.hid_new_bias;
    item_ch.valid           <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    gru_outputs_due.push_back(gru_unit_model(w));
  endtask

  task automatic test_zero_word();
    send_word(uniform_word('0));
  endtask

  task automatic test_field_extremes();
    data_t pats [4];
    pats[0] = data_t'(16'h7FFF);
    pats[1] = data_t'(16'h8000);
    pats[2] = data_t'(16'h5555);
    pats[3] = data_t'(16'hAAAA);
    foreach (pats[i]) send_word(uniform_word(pats[i]));
  endtask

  task automatic test_absent_bias();
    repeat (3) send_word(rand_word(MIX_NO_BIAS));
  endtask

  // gate sums of both signs; candidate sums just inside, at and beyond the table edges
  task automatic test_far_inputs();
    longint    targets [6];
    longint    rest;
    data_t     a;
    data_t     b;
    data_t     c;
    gru_word_t w;
    targets = '{-32769, -32768, 32767, 32768, 98301, -98304};
    foreach (targets[i]) begin
      w = uniform_word('0);
      w.prev_hidden = rand_value(MIX_FULL);
      rest = targets[i];
      a = data_t'(sat_data(rest));
      rest -= a;
      b = data_t'(sat_data(rest));
      rest -= b;
      c = data_t'(sat_data(rest));
      w.in_reset_pre   = a;
      w.hid_reset_pre  = b;
      w.reset_bias_sum = c;
      w.in_new_pre     = a;
      w.in_new_bias    = b;
      rest = -targets[i];
      a = data_t'(sat_data(rest));
      rest -= a;
      b = data_t'(sat_data(rest));
      rest -= b;
      w.in_update_pre   = a;
      w.hid_update_pre  = b;
      w.update_bias_sum = data_t'(sat_data(rest));
      send_word(w);
    end
  endtask

  // hn' saturates both ways and just past the limits
  task automatic test_wide_sums();
    data_t     hn [4];
    data_t     bhn [4];
    gru_word_t w;
    hn  = '{data_t'(32767), data_t'(-32768), data_t'(32767), data_t'(-32768)};
    bhn = '{data_t'(32767), data_t'(-32768), data_t'(1), data_t'(-1)};
    foreach (hn[i]) begin
      w = rand_word(MIX_GATED);
      w.hid_new_pre  = hn[i];
      w.hid_new_bias = bhn[i];
      send_word(w);
    end
  endtask

  // candidate input on exact segment breakpoints (hn' zero, so r*hn' drops out)
  task automatic test_segment_knees();
    int        knees [6];
    gru_word_t w;
    knees = '{0, 1, 31, 32, 33, 63};
    foreach (knees[i]) begin
      w = uniform_word('0);
      w.in_new_pre    = data_t'(-32768 + 1024 * knees[i]);
      w.in_reset_pre  = data_t'(-32768 + 1024 * knees[i]);
      w.in_update_pre = data_t'(-32768 + 1024 * knees[i] + 1);
      w.prev_hidden   = rand_value(MIX_FULL);
      send_word(w);
    end
  endtask

  task automatic test_random_words(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) send_word(rand_word(MIX_FULL));
      else if (r < 70) send_word(rand_word(MIX_GATED));
      else if (r < 85) send_word(rand_word(MIX_NO_BIAS));
      else send_word(rand_word(MIX_EDGES));
    end
  endtask

  task automatic test_back_to_back(int count);
    send_no_idle = 1'b1;
    sink_no_idle = 1'b1;
    test_random_words(count);
    send_no_idle = 1'b0;
    sink_no_idle = 1'b0;
  endtask

  // result side holds off while words keep coming, so the pipeline fills and stalls input
  task automatic test_output_stall();
    send_no_idle = 1'b1;
    hold_req     = 1'b1;
    repeat (64) send_word(rand_word(MIX_GATED));
    send_no_idle = 1'b0;
  endtask

  initial begin : result_sink
    gru_out_t exp_out;
    int       idle_left;
    int       hold_left;
    idle_left = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (gru_outputs_due.size() == 0) begin
          $error("result word with none outstanding: next_hidden=%0d", result_ch.next_hidden);
          errors++;
        end else begin
          exp_out = gru_outputs_due.pop_front();
          if (result_ch.next_hidden !== exp_out.next_hidden) begin
            $error("next_hidden: expected %0d, got %0d",
                   exp_out.next_hidden, result_ch.next_hidden);
            errors++;
          end
          if (result_ch.reset_gate !== exp_out.reset_gate) begin
            $error("reset_gate: expected %0d, got %0d",
                   exp_out.reset_gate, result_ch.reset_gate);
            errors++;
          end
          if (result_ch.update_gate !== exp_out.update_gate) begin
            $error("update_gate: expected %0d, got %0d",
                   exp_out.update_gate, result_ch.update_gate);
            errors++;
          end
          if (result_ch.new_gate !== exp_out.new_gate) begin
            $error("new_gate: expected %0d, got %0d",
                   exp_out.new_gate, result_ch.new_gate);
            errors++;
          end
          if (result_ch.hid_new_biased !== exp_out.hid_new_biased) begin
            $error("hid_new_biased: expected %0d, got %0d",
                   exp_out.hid_new_biased, result_ch.hid_new_biased);
            errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_left > 0 && !sink_no_idle) begin
        idle_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        idle_left = 0;
        if (!sink_no_idle && $urandom_range(3) == 0) idle_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $error("no word moved on either channel for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_ch.valid           = 1'b0;
    item_ch.in_reset_pre    = '0;
    item_ch.in_update_pre   = '0;
    item_ch.in_new_pre      = '0;
    item_ch.hid_reset_pre   = '0;
    item_ch.hid_update_pre  = '0;
    item_ch.hid_new_pre     = '0;
    item_ch.prev_hidden     = '0;
    item_ch.reset_bias_sum  = '0;
    item_ch.update_bias_sum = '0;
    item_ch.in_new_bias     = '0;
    item_ch.hid_new_bias    = '0;
    for (int k = 0; k <= TANH_SEGMENTS; k++) tanh_knee[k] = knee_value(k);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_zero_word();
    test_field_extremes();
    test_absent_bias();
    test_far_inputs();
    test_wide_sums();
    test_segment_knees();
    test_random_words(500);
    test_back_to_back(200);
    test_output_stall();
    test_random_words(480);

    item_ch.valid <= 1'b0;
    while (gru_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
